// ----- rtl/core/sdep_pkg.sv -----
// ----------------------------------------------------------------------------
// sdep_pkg
// Shared types, character constants and the prefix table for the SSE
// data event parser.
// ----------------------------------------------------------------------------
package sdep_pkg;

  localparam int unsigned SDEP_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [2:0] PREFIX_LEN = 3'd5;

  typedef enum logic {
    CMD_BYTE   = 1'b0,
    CMD_FINISH = 1'b1
  } sdep_cmd_t;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_EVENT_END = 1'b1
  } sdep_kind_t;

  typedef enum logic [5:0] {
    PH_LINE_START  = 6'b000001,
    PH_START_CR    = 6'b000010,
    PH_MATCHING    = 6'b000100,
    PH_AFTER_COLON = 6'b001000,
    PH_IN_VALUE    = 6'b010000,
    PH_IGNORING    = 6'b100000
  } sdep_phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] stream_byte;
  } sdep_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       last;
  } sdep_out_t;

  typedef struct packed {
    sdep_phase_t phase;
    logic [2:0]  prefix_position;
    logic        held_carriage_return;
    logic        event_has_data;
  } sdep_state_t;

  // Up to two result words produced by one input word.
  typedef struct packed {
    logic      r0_valid;
    sdep_out_t r0;
    logic      r1_valid;
    sdep_out_t r1;
  } sdep_res_t;

  // Characters of the "data:" field name by position.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h64;  // d
      3'd1:    ch = 8'h61;  // a
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h61;  // a
      3'd4:    ch = 8'h3A;  // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/sdep_step.sv -----
// ----------------------------------------------------------------------------
// sdep_step
// Next-state and result logic for one stream word.
// ----------------------------------------------------------------------------
module sdep_step
  import sdep_pkg::*;
(
  input  sdep_state_t cur,
  input  sdep_in_t    word,
  output sdep_state_t nxt,
  output sdep_res_t   res
);

  logic [7:0] c;
  logic [2:0] pos_inc;

  assign c       = word.stream_byte;
  assign pos_inc = cur.prefix_position + 3'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    if (word.command == CMD_FINISH) begin
      nxt.phase                = PH_LINE_START;
      nxt.prefix_position      = '0;
      nxt.held_carriage_return = 1'b0;
      if (cur.event_has_data) begin
        res.r0_valid = 1'b1;
        res.r0       = '{kind: KIND_EVENT_END, payload_byte: 8'h00, last: 1'b0};
      end
      nxt.event_has_data = 1'b0;
    end else begin
      unique case (cur.phase)
        PH_LINE_START, PH_START_CR: begin
          if (c == CH_LF) begin
            if (cur.event_has_data) begin
              res.r0_valid = 1'b1;
              res.r0       = '{kind: KIND_EVENT_END, payload_byte: 8'h00, last: 1'b0};
            end
            nxt.event_has_data       = 1'b0;
            nxt.phase                = PH_LINE_START;
            nxt.prefix_position      = '0;
            nxt.held_carriage_return = 1'b0;
          end else if (cur.phase == PH_START_CR) begin
            nxt.phase = PH_IGNORING;
          end else if (c == CH_CR) begin
            nxt.phase = PH_START_CR;
          end else if (c == prefix_char(3'd0)) begin
            nxt.phase           = PH_MATCHING;
            nxt.prefix_position = 3'd1;
          end else begin
            nxt.phase = PH_IGNORING;
          end
        end
        PH_MATCHING: begin
          if (c == CH_LF) begin
            nxt.phase                = PH_LINE_START;
            nxt.prefix_position      = '0;
            nxt.held_carriage_return = 1'b0;
          end else if (cur.prefix_position < PREFIX_LEN &&
                       c == prefix_char(cur.prefix_position)) begin
            nxt.prefix_position = pos_inc;
            if (pos_inc == PREFIX_LEN) begin
              // A further data line of the same event opens with a separator.
              if (cur.event_has_data) begin
                res.r0_valid = 1'b1;
                res.r0       = '{kind: KIND_PAYLOAD, payload_byte: CH_LF, last: 1'b0};
              end
              nxt.event_has_data  = 1'b1;
              nxt.phase           = PH_AFTER_COLON;
              nxt.prefix_position = '0;
            end
          end else begin
            nxt.phase           = PH_IGNORING;
            nxt.prefix_position = '0;
          end
        end
        PH_AFTER_COLON: begin
          if (c == CH_LF) begin
            nxt.phase                = PH_LINE_START;
            nxt.prefix_position      = '0;
            nxt.held_carriage_return = 1'b0;
          end else if (c == CH_SPACE) begin
            nxt.phase = PH_IN_VALUE;
          end else if (c == CH_CR) begin
            nxt.held_carriage_return = 1'b1;
            nxt.phase                = PH_IN_VALUE;
          end else begin
            res.r0_valid = 1'b1;
            res.r0       = '{kind: KIND_PAYLOAD, payload_byte: c, last: 1'b0};
            nxt.phase    = PH_IN_VALUE;
          end
        end
        PH_IN_VALUE: begin
          if (c == CH_LF) begin
            nxt.phase                = PH_LINE_START;
            nxt.prefix_position      = '0;
            nxt.held_carriage_return = 1'b0;
          end else if (c == CH_CR) begin
            if (cur.held_carriage_return) begin
              res.r0_valid = 1'b1;
              res.r0       = '{kind: KIND_PAYLOAD, payload_byte: CH_CR, last: 1'b0};
            end
            nxt.held_carriage_return = 1'b1;
          end else begin
            if (cur.held_carriage_return) begin
              res.r0_valid = 1'b1;
              res.r0       = '{kind: KIND_PAYLOAD, payload_byte: CH_CR, last: 1'b0};
              res.r1_valid = 1'b1;
              res.r1       = '{kind: KIND_PAYLOAD, payload_byte: c, last: 1'b0};
            end else begin
              res.r0_valid = 1'b1;
              res.r0       = '{kind: KIND_PAYLOAD, payload_byte: c, last: 1'b0};
            end
            nxt.held_carriage_return = 1'b0;
          end
        end
        default: begin
          // Ignored lines, and any stray phase code, wait for the next LF.
          if (c == CH_LF) begin
            nxt.phase                = PH_LINE_START;
            nxt.prefix_position      = '0;
            nxt.held_carriage_return = 1'b0;
          end else begin
            nxt.held_carriage_return = 1'b0;
          end
        end
      endcase
    end

    if (res.r1_valid) begin
      res.r1.last = 1'b1;
    end else if (res.r0_valid) begin
      res.r0.last = 1'b1;
    end
  end

endmodule

// ----- rtl/core/sdep_out_queue.sv -----
// ----------------------------------------------------------------------------
// sdep_out_queue
// Small result queue that takes up to two words per cycle and hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module sdep_out_queue
  import sdep_pkg::*;
#(
  parameter int unsigned DEPTH = SDEP_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sdep_res_t                  push,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sdep_out_t                  out_word,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  sdep_out_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level_next;
  logic             pop;
  logic [LVL_W-1:0] push_cnt;

  assign out_valid = (level != '0);
  assign out_word  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_cnt  = LVL_W'(push.r0_valid) + LVL_W'(push.r1_valid);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.r1_valid) begin
      wr_ptr_next = ptr_inc(ptr_inc(wr_ptr));
    end else if (push.r0_valid) begin
      wr_ptr_next = ptr_inc(wr_ptr);
    end
    level_next = level + push_cnt - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.r0_valid) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.r1_valid) begin
      mem[ptr_inc(wr_ptr)] <= push.r1;
    end
  end

endmodule

// ----- rtl/core/sse_data_event_parser_core.sv -----
// ----------------------------------------------------------------------------
// sse_data_event_parser_core
// Streaming parser for the data lines of a Server-Sent Events byte stream.
// Each input word carries one stream byte or a finish command. Payload bytes
// of "data:" lines come out one per output word as they arrive, an LF word
// separates further data lines of one event, and an event-complete word
// follows a blank line or a finish when the event saw a data line. The block
// takes one input word per cycle while its input register is free or moving
// on. An input word is registered, evaluated by the parser step once the
// queue has room, and its results land in a small result queue. A word
// yielding two results (a held CR followed by a value byte) fills two
// output words. The pending word moves on only while the queue has room for
// two results, so the sustained rate is one byte per cycle whenever the
// consumer keeps up, and backpressure on the output reaches the input once
// the queue fills. The last field marks the final result word of each input
// word. No memory clearing is needed after reset.
// ----------------------------------------------------------------------------
module sse_data_event_parser_core
  import sdep_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SDEP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  sdep_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output sdep_out_t result
);

  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Input register holding the word waiting for the parser step.
  logic        pend_valid;
  sdep_in_t    pend;

  // Parser state and the step result for the pending word.
  sdep_state_t state;
  sdep_state_t state_next;
  sdep_res_t   step_res;
  sdep_res_t   push;

  logic [LVL_W-1:0] level;
  logic             space;
  logic             advance;

  // The pending word is processed once the queue can take both of its
  // possible results.
  assign space      = (level <= LVL_W'(QUEUE_DEPTH - 2));
  assign advance    = pend_valid && space;
  assign item_ready = !pend_valid || advance;

  sdep_step u_step (
    .cur  (state),
    .word (pend),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_comb begin
    push          = step_res;
    push.r0_valid = step_res.r0_valid && advance;
    push.r1_valid = step_res.r1_valid && advance;
  end

  sdep_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_word  (result),
    .level     (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid                 <= 1'b0;
      state.phase                <= PH_LINE_START;
      state.prefix_position      <= '0;
      state.held_carriage_return <= 1'b0;
      state.event_has_data       <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        pend_valid <= 1'b1;
      end else if (advance) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      pend <= item;
    end
  end

`ifndef SYNTH
  // The queue never holds more words than it has slots.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // An accepted word is always waiting in the input register next cycle.
  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> pend_valid)
    else $error("accepted word lost");

  // A second result is only produced together with a first one.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.r1_valid |-> push.r0_valid)
    else $error("second result without first");

  // Event-complete words carry a zero payload.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_EVENT_END |-> result.payload_byte == 8'h00)
    else $error("event-complete word with nonzero payload");
`endif

endmodule

// ----- test/sse_data_event_parser_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sse_data_event_parser_core_test
// Self-checking bench for the SSE data event parser. A directed opening and a
// long random stream of mostly well-formed SSE lines are pushed through the
// input channel in bursts, while the output channel stalls on its own
// pattern. Every output word is checked against a line-state tracker that
// runs alongside the block.
// ----------------------------------------------------------------------------
module sse_data_event_parser_core_test;
  import sdep_pkg::*;

  // Cycles in which neither channel moves a word before the run is abandoned.
  localparam int IDLE_LIMIT = 2000;
  // Extra cycles allowed after the last expected word, covering the pipeline.
  localparam int TAIL_CYCLES = 20;
  // Target length of the stream is this plus 18 words, the directed opening included.
  localparam int RANDOM_WORDS = 1850;

  // The field name that opens a data line, first character in the top byte.
  localparam logic [39:0] DATA_FIELD = "data:";

  // One queued input word, plus a flag that makes the driver hold it back
  // until the block has delivered everything it still owes.
  typedef struct {
    sdep_in_t w;
    bit       hold_off;
  } stream_word_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  sdep_in_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  sdep_out_t result;

  // Words still to be offered to the block, and output words the tracker
  // says the block still owes, oldest first.
  stream_word_t stream_words[$];
  sdep_out_t    event_words_due[$];

  // Line-state tracker: where the current line stands, how much of the field
  // name has matched, whether a CR of the value is held back, and whether the
  // open event has seen a data line.
  sdep_phase_t trk_phase = PH_LINE_START;
  logic [2:0]  trk_pos = '0;
  logic        trk_cr_held = 1'b0;
  logic        trk_has_data = 1'b0;

  bit mark_drain = 1'b0;
  bit item_taken = 1'b0;
  int bad_words = 0;
  int idle_cycles = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  sse_data_event_parser_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tracker
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] field_char(input logic [2:0] pos);
    return DATA_FIELD[8 * (4 - pos) +: 8];
  endfunction

  function automatic void close_line();
    trk_phase   = PH_LINE_START;
    trk_pos     = '0;
    trk_cr_held = 1'b0;
  endfunction

  // Advances the tracker by one accepted input word and queues the output
  // words it must cause, marking the final one with last.
  task automatic parse_step(input sdep_in_t w);
    sdep_out_t  r [0:1];
    int         n;
    logic [7:0] c;
    n = 0;
    c = w.stream_byte;
    if (w.command == CMD_FINISH) begin
      // Finish drops whatever the line held and closes an open event.
      close_line();
      if (trk_has_data) begin
        r[n] = '{kind: KIND_EVENT_END, payload_byte: 8'h00, last: 1'b0};
        n++;
        trk_has_data = 1'b0;
      end
    end else begin
      case (trk_phase)
        PH_LINE_START, PH_START_CR: begin
          if (c == CH_LF) begin
            // Blank line, either empty or a lone CR.
            if (trk_has_data) begin
              r[n] = '{kind: KIND_EVENT_END, payload_byte: 8'h00, last: 1'b0};
              n++;
              trk_has_data = 1'b0;
            end
            close_line();
          end else if (trk_phase == PH_START_CR) begin
            trk_phase = PH_IGNORING;
          end else if (c == CH_CR) begin
            trk_phase = PH_START_CR;
          end else if (c == field_char(3'd0)) begin
            trk_phase = PH_MATCHING;
            trk_pos   = 3'd1;
          end else begin
            trk_phase = PH_IGNORING;
          end
        end
        PH_MATCHING: begin
          if (c == CH_LF) begin
            close_line();
          end else if (trk_pos < PREFIX_LEN && c == field_char(trk_pos)) begin
            trk_pos = trk_pos + 3'd1;
            if (trk_pos == PREFIX_LEN) begin
              // The separator goes out as soon as a further colon matches.
              if (trk_has_data) begin
                r[n] = '{kind: KIND_PAYLOAD, payload_byte: CH_LF, last: 1'b0};
                n++;
              end
              trk_has_data = 1'b1;
              trk_phase    = PH_AFTER_COLON;
              trk_pos      = '0;
            end
          end else begin
            trk_phase = PH_IGNORING;
            trk_pos   = '0;
          end
        end
        PH_AFTER_COLON: begin
          if (c == CH_LF) begin
            close_line();
          end else if (c == CH_SPACE) begin
            trk_phase = PH_IN_VALUE;
          end else if (c == CH_CR) begin
            trk_cr_held = 1'b1;
            trk_phase   = PH_IN_VALUE;
          end else begin
            r[n] = '{kind: KIND_PAYLOAD, payload_byte: c, last: 1'b0};
            n++;
            trk_phase = PH_IN_VALUE;
          end
        end
        PH_IN_VALUE: begin
          if (c == CH_LF) begin
            close_line();
          end else begin
            // A held CR is real data once anything but LF follows it.
            if (trk_cr_held) begin
              r[n] = '{kind: KIND_PAYLOAD, payload_byte: CH_CR, last: 1'b0};
              n++;
            end
            if (c == CH_CR) begin
              trk_cr_held = 1'b1;
            end else begin
              trk_cr_held = 1'b0;
              r[n] = '{kind: KIND_PAYLOAD, payload_byte: c, last: 1'b0};
              n++;
            end
          end
        end
        default: begin
          if (c == CH_LF)
            close_line();
          else
            trk_cr_held = 1'b0;
        end
      endcase
    end
    if (n > 0)
      r[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++)
      event_words_due.push_back(r[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------

  function automatic void add_word(input sdep_cmd_t cmd, input logic [7:0] b);
    stream_word_t sw;
    sw.w.command     = cmd;
    sw.w.stream_byte = b;
    sw.hold_off      = mark_drain;
    mark_drain       = 1'b0;
    stream_words.push_back(sw);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_word(CMD_BYTE, b);
  endfunction

  // Pushes the first count characters of the data field name.
  function automatic void add_field_name(input int count);
    for (int i = 0; i < count; i++)
      add_byte(field_char(i[2:0]));
  endfunction

  function automatic logic [7:0] rand_any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // A byte for a line body: never LF, with CR and space made common.
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1:    b = CH_CR;
      2:       b = CH_SPACE;
      default: begin
        b = rand_any_byte();
        if (b == CH_LF)
          b = 8'hFF;
      end
    endcase
    return b;
  endfunction

  function automatic void add_blank_line();
    if ($urandom_range(0, 1))
      add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int len;
    // Directed opening: space skip, extreme bytes, held CRs in a value, an
    // empty further data line with its separator, a lone-CR blank line, a
    // CR-started ignored line, a CR inside the field name, and a finish.
    add_field_name(5);
    add_byte(CH_SPACE);
    add_byte(8'h01);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_CR);
    add_byte("x");
    add_byte(CH_LF);
    add_field_name(5);
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte("q");
    add_byte(CH_LF);
    add_byte("d");
    add_byte(CH_CR);
    add_word(CMD_FINISH, 8'hFF);

    // The first random word waits for the opening to drain completely.
    mark_drain = 1'b1;
    while (stream_words.size() < RANDOM_WORDS + 18) begin
      case ($urandom_range(0, 99)) inside
        [0:49]: begin
          // Data line with random content; some end the event right away.
          if ($urandom_range(0, 19) == 0)
            mark_drain = 1'b1;
          add_field_name(5);
          if ($urandom_range(0, 1))
            add_byte(CH_SPACE);
          len = $urandom_range(0, 8);
          for (int i = 0; i < len; i++)
            add_byte(rand_body_byte());
          case ($urandom_range(0, 9))
            0, 1:    begin add_byte(CH_CR); add_byte(CH_LF); end
            2:       add_word(CMD_FINISH, rand_any_byte());
            default: add_byte(CH_LF);
          endcase
          if ($urandom_range(0, 4) < 2)
            add_blank_line();
        end
        [50:61]: add_blank_line();
        [62:71]: begin
          // Another field or a comment line.
          case ($urandom_range(0, 3))
            0:       add_byte(":");
            1:       add_byte("e");
            2:       add_byte("i");
            default: add_byte(rand_body_byte());
          endcase
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++)
            add_byte(rand_body_byte());
          add_byte(CH_LF);
        end
        [72:83]: begin
          // Field name broken part way through.
          add_field_name($urandom_range(1, 4));
          case ($urandom_range(0, 2))
            0:       add_byte(CH_CR);
            1:       add_byte(rand_body_byte());
            default: ;
          endcase
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++)
            add_byte(rand_body_byte());
          add_byte(CH_LF);
        end
        [84:89]: add_word(CMD_FINISH, rand_any_byte());
        default: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            add_byte(rand_any_byte());
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The driver's queue and valid only change at the falling edge, so they
    // are watched at the rising edge; the owed words only change at the
    // rising edge, so they are watched at the falling edge.
    while (stream_words.size() != 0 || item_valid)
      @(posedge clk);
    while (event_words_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (bad_words == 0 && event_words_due.size() == 0)
      $display("sse_data_event_parser_core: match");
    else
      $display("sse_data_event_parser_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver: bursts of words separated by random gaps. A word stays put
  // until the checker saw it accepted at the previous rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    stream_word_t sw;
    sdep_in_t     nxt_word;
    logic         nxt_valid;
    nxt_word  = item;
    nxt_valid = 1'b0;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (item_valid && !item_taken) begin
      nxt_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (stream_words.size() != 0 &&
                 !(stream_words[0].hold_off && event_words_due.size() != 0)) begin
      sw        = stream_words.pop_front();
      nxt_word  = sw.w;
      nxt_valid = 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // New burst; a quarter of them follow on with no gap at all.
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    item_valid <= nxt_valid;
    item       <= nxt_word;
  end

  // ---------------------------------------------------------------------------
  // Output stall pattern: every so often a new mode is picked among always
  // ready, mostly ready, a fixed periodic stall and mostly stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(64, 256);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
    case (stall_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 3) != 0);
      2:       rdy = (stall_phase >= 2);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    result_ready <= rst ? 1'b0 : rdy;
  end

  // ---------------------------------------------------------------------------
  // Checker: feeds accepted input words to the tracker, compares each output
  // word against the oldest one owed, and watches for a stalled run.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sdep_out_t due;
    item_taken = 1'b0;
    if (!rst) begin
      if (item_valid && item_ready) begin
        parse_step(item);
        item_taken = 1'b1;
      end
      if (result_valid && result_ready) begin
        if (event_words_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected word: kind %0d byte %02h last %0d",
                     result.kind, result.payload_byte, result.last);
        end else begin
          due = event_words_due.pop_front();
          if (result.kind !== due.kind || result.payload_byte !== due.payload_byte ||
              result.last !== due.last) begin
            bad_words++;
            if (bad_words <= 10)
              $display("word differs: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                       due.kind, due.payload_byte, due.last,
                       result.kind, result.payload_byte, result.last);
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sse_data_event_parser_core: mismatch");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
rtl/core/sdep_pkg.sv
rtl/core/sdep_step.sv
rtl/core/sdep_out_queue.sv
rtl/core/sse_data_event_parser_core.sv
test/sse_data_event_parser_core_test.sv
